FILE: hdl/poly_pkg.sv
// Shared types, constants and helpers for the Poly1305 authenticator.
package poly_pkg;

  localparam int LimbW  = 26;
  localparam int NLimbs = 5;

  localparam logic [63:0] RClampLo = 64'h0fff_fffc_0fff_ffff;
  localparam logic [63:0] RClampHi = 64'h0fff_fffc_0fff_fffc;
  localparam logic [25:0] LimbMask = 26'h3ff_ffff;

  typedef logic [25:0] limb_t;
  typedef logic [26:0] acc_limb_t;
  typedef logic [27:0] sum_limb_t;
  typedef logic [28:0] coef_t;
  typedef logic [56:0] prod_t;
  typedef logic [60:0] wide_t;
  typedef logic [2:0]  idx_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic carry;
    logic acc_wb;
    logic fin_load;
    logic sel;
    logic tag;
    idx_t row;
    idx_t sum_row;
    idx_t step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // top limb holds bits 104..127 and reads zero above bit 127
  function automatic limb_t limb_of(input logic [63:0] lo, input logic [63:0] hi,
                                    input int k);
    logic [129:0] v;
    begin
      v = {2'b00, hi, lo};
      limb_of = v[k*LimbW +: LimbW];
    end
  endfunction

endpackage

FILE: hdl/poly_ctrl.sv
// Sequencer for block absorb, carry passes and tag finish.
module poly_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_nonempty,
  input  logic             in_last,
  output logic             in_ready,
  input  poly_pkg::status_t status,
  output poly_pkg::cmd_t    cmd
);
  import poly_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_CARRY = 3'd3;
  localparam logic [2:0] ST_FLOAD = 3'd4;
  localparam logic [2:0] ST_SEL   = 3'd5;
  localparam logic [2:0] ST_TAG   = 3'd6;

  logic [2:0] state, state_next;
  idx_t       cnt, cnt_next;
  logic       fin, fin_next;
  logic       pass, pass_next;
  logic       last_q, last_q_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    fin_next    = fin;
    pass_next   = pass;
    last_q_next = last_q;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          last_q_next = in_last;
          cnt_next    = '0;
          if (in_nonempty) begin
            cmd.load   = 1'b1;
            state_next = ST_MUL;
          end else if (in_last) begin
            cmd.fin_load = 1'b1;
            fin_next     = 1'b1;
            pass_next    = 1'b0;
            state_next   = ST_CARRY;
          end
        end
      end
      ST_MUL: begin
        cmd.mul     = 1'b1;
        cmd.row     = cnt;
        cmd.sum     = (cnt != 3'd0);
        cmd.sum_row = cnt - 3'd1;
        if (cnt == 3'd4) begin
          state_next = ST_SUM;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_SUM: begin
        cmd.sum     = 1'b1;
        cmd.sum_row = 3'd4;
        cnt_next    = '0;
        fin_next    = 1'b0;
        state_next  = ST_CARRY;
      end
      ST_CARRY: begin
        cmd.carry = 1'b1;
        cmd.step  = cnt;
        if (cnt == 3'd5) begin
          cnt_next = '0;
          if (!fin) begin
            cmd.acc_wb = 1'b1;
            state_next = last_q ? ST_FLOAD : ST_IDLE;
          end else if (!pass) begin
            pass_next = 1'b1;
          end else begin
            state_next = ST_SEL;
          end
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_FLOAD: begin
        cmd.fin_load = 1'b1;
        fin_next     = 1'b1;
        pass_next    = 1'b0;
        cnt_next     = '0;
        state_next   = ST_CARRY;
      end
      ST_SEL: begin
        cmd.sel    = 1'b1;
        state_next = ST_TAG;
      end
      ST_TAG: begin
        if (status.out_free) begin
          cmd.tag    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      fin    <= 1'b0;
      pass   <= 1'b0;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      fin    <= fin_next;
      pass   <= pass_next;
      last_q <= last_q_next;
    end
  end

endmodule

FILE: hdl/poly_dp.sv
// Limb datapath: key registers, accumulator, row multipliers, carry engine, tag.
module poly_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [63:0]       cfg_data,
  input  logic [63:0]       block_lo,
  input  logic [63:0]       block_hi,
  input  logic [4:0]        byte_count,
  input  poly_pkg::cmd_t    cmd,
  output poly_pkg::status_t status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [127:0]      out_tag
);
  import poly_pkg::*;

  localparam logic [1:0] REG_R_LO = 2'd0;
  localparam logic [1:0] REG_R_HI = 2'd1;
  localparam logic [1:0] REG_S_LO = 2'd2;
  localparam logic [1:0] REG_S_HI = 2'd3;

  logic [63:0] key_r_lo, key_r_hi, key_s_lo, key_s_hi;
  acc_limb_t   acc [NLimbs];
  sum_limb_t   h   [NLimbs];
  prod_t       prod[NLimbs];
  wide_t       d   [NLimbs];
  wide_t       dn  [NLimbs];
  limb_t       r   [NLimbs];
  coef_t       r5  [NLimbs];
  limb_t       m   [NLimbs];
  logic [63:0] pad_lo, pad_hi;
  logic        hibit;
  logic [5:0]  sh;
  wide_t       c;
  wide_t       row_sum;
  sum_limb_t   g   [NLimbs];
  sum_limb_t   gc;
  logic [63:0] hlo, hhi;
  logic [63:0] h64 [NLimbs];

  assign status.out_free = !out_valid || out_ready;

  // clamped r limbs and their times-five images
  always_comb begin
    for (int k = 0; k < NLimbs; k++) begin
      r[k]  = limb_of(key_r_lo & RClampLo, key_r_hi & RClampHi, k);
      r5[k] = {3'b000, r[k]} + {1'b0, r[k], 2'b00};
    end
  end

  // pad the block as its byte count says
  always_comb begin
    pad_lo = block_lo;
    pad_hi = block_hi;
    hibit  = 1'b0;
    sh     = {byte_count[2:0], 3'b000};
    if (byte_count[4]) begin
      hibit = 1'b1;
    end else if (byte_count > 5'd8) begin
      pad_hi = (block_hi & ((64'd1 << sh) - 64'd1)) | (64'd1 << sh);
    end else if (byte_count == 5'd8) begin
      pad_hi = 64'd1;
    end else begin
      pad_lo = (block_lo & ((64'd1 << sh) - 64'd1)) | (64'd1 << sh);
      pad_hi = 64'd0;
    end
    for (int k = 0; k < NLimbs; k++) begin
      m[k] = limb_of(pad_lo, pad_hi, k);
    end
  end

  // one carry step of the pass
  always_comb begin
    for (int k = 0; k < NLimbs; k++) dn[k] = d[k];
    c = '0;
    unique case (cmd.step)
      3'd0, 3'd5: begin
        c     = {26'd0, d[0][60:26]};
        dn[0] = {35'd0, d[0][25:0]};
        dn[1] = d[1] + c;
      end
      3'd1: begin
        c     = {26'd0, d[1][60:26]};
        dn[1] = {35'd0, d[1][25:0]};
        dn[2] = d[2] + c;
      end
      3'd2: begin
        c     = {26'd0, d[2][60:26]};
        dn[2] = {35'd0, d[2][25:0]};
        dn[3] = d[3] + c;
      end
      3'd3: begin
        c     = {26'd0, d[3][60:26]};
        dn[3] = {35'd0, d[3][25:0]};
        dn[4] = d[4] + c;
      end
      3'd4: begin
        c     = {26'd0, d[4][60:26]};
        dn[4] = {35'd0, d[4][25:0]};
        dn[0] = d[0] + (c << 2) + c;
      end
      default: c = '0;
    endcase
  end

  always_comb begin
    row_sum = '0;
    for (int k = 0; k < NLimbs; k++) row_sum = row_sum + {4'd0, prod[k]};
  end

  // conditional subtraction of p: h + 5 overflows bit 130 exactly when h >= p
  always_comb begin
    gc = 28'd5;
    for (int k = 0; k < NLimbs; k++) begin
      g[k] = d[k][27:0] + gc;
      gc   = {26'd0, g[k][27:26]};
      g[k] = {2'b00, g[k][25:0]};
    end
  end

  always_comb begin
    for (int k = 0; k < NLimbs; k++) h64[k] = {36'd0, d[k][27:0]};
    hlo = h64[0] | (h64[1] << 26) | ((h64[2] & 64'hfff) << 52);
    hhi = (h64[2] >> 12) | (h64[3] << 14) | ((h64[4] & 64'hff_ffff) << 40);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_r_lo <= '0;
      key_r_hi <= '0;
      key_s_lo <= '0;
      key_s_hi <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_R_LO: key_r_lo <= cfg_data;
        REG_R_HI: key_r_hi <= cfg_data;
        REG_S_LO: key_s_lo <= cfg_data;
        REG_S_HI: key_s_hi <= cfg_data;
        default:  key_r_lo <= key_r_lo;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NLimbs; k++) acc[k] <= '0;
    end else if (cmd.acc_wb) begin
      for (int k = 0; k < NLimbs; k++) acc[k] <= dn[k][26:0];
    end else if (cmd.tag) begin
      for (int k = 0; k < NLimbs; k++) acc[k] <= '0;
    end
  end

  // add the block, with 2^128 on the top limb for a full block
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < NLimbs; k++) begin
        h[k] <= {1'b0, acc[k]} + {2'b00, m[k]} +
                ((k == NLimbs - 1) ? {3'b000, hibit, 24'd0} : 28'd0);
      end
    end
  end

  // one row of five partial products per cycle
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int j = 0; j < NLimbs; j++) begin
        if (cmd.row >= idx_t'(j)) prod[j] <= h[j] * {3'b000, r[cmd.row - idx_t'(j)]};
        else                      prod[j] <= h[j] * r5[cmd.row + 3'd5 - idx_t'(j)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      for (int k = 0; k < NLimbs; k++) d[k] <= {34'd0, acc[k]};
    end else if (cmd.carry) begin
      for (int k = 0; k < NLimbs; k++) d[k] <= dn[k];
    end else if (cmd.sel) begin
      if (gc != 28'd0) begin
        for (int k = 0; k < NLimbs; k++) d[k] <= {33'd0, g[k]};
      end
    end else if (cmd.sum) begin
      d[cmd.sum_row] <= row_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.tag) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tag) out_tag <= {hhi, hlo} + {key_s_hi, key_s_lo};
  end

endmodule

FILE: hdl/poly1305_mac_top.sv
// Top level of the Poly1305 one-time authenticator.
//
// Usage: write the key once per message through cfg_we/cfg_addr/cfg_data
// (0 = r low, 1 = r high, 2 = s low, 3 = s high) while the block is idle.
// r is clamped internally. Stream 16-byte blocks on the s_ side; tlast
// marks the final word of a message, and only that word produces a tag
// word on the m_ side (bytes 0-15 of the tag, little-endian).
// Byte count 16 or more is a full block, 1..15 a padded partial block, 0 absorbs
// nothing (tlast with count 0 tags the message as it stands).
// A block runs 5 multiplier rows, one row sum and 6 carry steps after
// acceptance, and no new word is taken until it is done. The final word
// adds 12 steps for two full carry passes, the conditional subtraction
// of p, then the tag add.
// Throughput is set by the shared row of five limb multipliers and the
// single-step carry engine.
// Reset clears the key, the accumulator and the output valid.
// A stalled receiver holds the tag in the output register; further
// non-last words are still accepted, and the next tag waits for space.
module poly1305_mac_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // block_lo[63:0], block_hi[127:64], byte_count[132:128]
  input  logic         s_tlast,   // last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // tag_lo[63:0], tag_hi[127:64]
);
  import poly_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    nonempty;

  // zero byte count means nothing to absorb
  assign nonempty = (s_tdata[132:128] != 5'd0);

  poly_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_nonempty (nonempty),
    .in_last     (s_tlast),
    .in_ready    (s_tready),
    .status      (status),
    .cmd         (cmd)
  );

  poly_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .block_lo   (s_tdata[63:0]),
    .block_hi   (s_tdata[127:64]),
    .byte_count (s_tdata[132:128]),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_tag    (m_tdata)
  );

endmodule

FILE: verif/poly1305_mac_top_tb.sv
// Self-checking stream testbench for the Poly1305 authenticator top level.
`timescale 1ns / 1ps

module poly1305_mac_top_tb;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  cnt;
    logic        last;
  } block_word_t;

  typedef enum logic [1:0] {
    REG_R_LO = 2'd0,
    REG_R_HI = 2'd1,
    REG_S_LO = 2'd2,
    REG_S_HI = 2'd3
  } key_reg_e;

  localparam int WatchdogLimit = 20000;
  // Tail wait covers the final-word latency of the block.
  localparam int DrainCycles = 60;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [63:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;

  poly1305_mac_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow copy of the key and the accumulator.
  logic [63:0]  key_r_lo, key_r_hi, key_s_lo, key_s_hi;
  logic [26:0]  acc [5];

  block_word_t  pending_words[$];
  logic [127:0] expected_tags[$];

  int  errors;
  int  send_idle_pct, recv_idle_pct;
  int  recv_hold_cycles;
  bit  send_pause;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void to_limbs(input logic [63:0] lo, input logic [63:0] hi,
                                   output logic [63:0] v [5]);
    logic [127:0] w;
    w = {hi, lo};
    for (int i = 0; i < 5; i++) v[i] = (i < 4) ? 64'(w[i*26 +: 26]) : 64'(w[127:104]);
  endfunction

  function automatic void carry_limbs(inout logic [63:0] h [5]);
    logic [63:0] c;
    for (int i = 0; i < 4; i++) begin
      c = h[i] >> 26; h[i] &= 64'h3ffffff; h[i+1] += c;
    end
    c = h[4] >> 26; h[4] &= 64'h3ffffff; h[0] += c * 5;
    c = h[0] >> 26; h[0] &= 64'h3ffffff; h[1] += c;
  endfunction

  task automatic absorb_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] hibit);
    logic [63:0] r [5];
    logic [63:0] m [5];
    logic [63:0] h [5];
    logic [63:0] d [5];
    to_limbs(key_r_lo & 64'h0ffffffc0fffffff, key_r_hi & 64'h0ffffffc0ffffffc, r);
    to_limbs(lo, hi, m);
    for (int i = 0; i < 5; i++) h[i] = 64'(acc[i]) + m[i];
    h[4] += hibit;
    for (int i = 0; i < 5; i++) begin
      d[i] = 0;
      for (int j = 0; j < 5; j++)
        d[i] += (i >= j) ? h[j] * r[i-j] : h[j] * 5 * r[i-j+5];
    end
    carry_limbs(d);
    for (int i = 0; i < 5; i++) acc[i] = d[i][26:0];
  endtask

  function automatic logic [127:0] finish_tag();
    logic [63:0] h [5];
    logic [63:0] g [5];
    logic [63:0] c, hlo, hhi, slo;
    for (int i = 0; i < 5; i++) h[i] = 64'(acc[i]);
    carry_limbs(h);
    carry_limbs(h);
    c = 5;
    for (int i = 0; i < 5; i++) begin
      g[i] = h[i] + c; c = g[i] >> 26; g[i] &= 64'h3ffffff;
    end
    if (c != 0) h = g;
    hlo = h[0] | (h[1] << 26) | ((h[2] & 64'hfff) << 52);
    hhi = (h[2] >> 12) | (h[3] << 14) | ((h[4] & 64'hffffff) << 40);
    slo = hlo + key_s_lo;
    hhi = hhi + key_s_hi + 64'(slo < hlo);
    for (int i = 0; i < 5; i++) acc[i] = '0;
    return {hhi, slo};
  endfunction

  // Advance the shadow accumulator for one accepted word.
  task automatic predict_word(input block_word_t w);
    logic [63:0] lo, hi;
    int sh;
    lo = w.lo; hi = w.hi;
    if (w.cnt >= 16) absorb_block(lo, hi, 64'd1 << 24);
    else if (w.cnt > 8) begin
      sh = 8 * (w.cnt - 8);
      absorb_block(lo, (hi & ((64'd1 << sh) - 1)) | (64'd1 << sh), 0);
    end else if (w.cnt == 8) absorb_block(lo, 64'd1, 0);
    else if (w.cnt > 0) begin
      sh = 8 * w.cnt;
      absorb_block((lo & ((64'd1 << sh) - 1)) | (64'd1 << sh), 64'd0, 0);
    end
    if (w.last) expected_tags.push_back(finish_tag());
  endtask

  // Driver: hold the word until accepted, then advance the queue.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_word(pending_words.pop_front());
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() > 0 && !send_pause &&
            $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {3'b0, pending_words[0].cnt, pending_words[0].hi, pending_words[0].lo};
          s_tlast  <= pending_words[0].last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted tag word and pace the receiver.
  always @(posedge clk) begin
    logic [127:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_tags.size() == 0) begin
          report_mismatch("unexpected tag_lo", m_tdata[63:0], 64'd0);
        end else begin
          want = expected_tags.pop_front();
          if (m_tdata[63:0] !== want[63:0]) report_mismatch("tag_lo", m_tdata[63:0], want[63:0]);
          if (m_tdata[127:64] !== want[127:64])
            report_mismatch("tag_hi", m_tdata[127:64], want[127:64]);
        end
      end
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles <= recv_hold_cycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Write one key register at a clock edge.
  task automatic write_key(input key_reg_e idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_R_LO: key_r_lo = val;
      REG_R_HI: key_r_hi = val;
      REG_S_LO: key_s_lo = val;
      default:  key_s_hi = val;
    endcase
  endtask

  task automatic load_key(input logic [63:0] rl, rh, sl, sh);
    write_key(REG_R_LO, rl);
    write_key(REG_R_HI, rh);
    write_key(REG_S_LO, sl);
    write_key(REG_S_HI, sh);
  endtask

  // Wait until every tag has come and the block has gone quiet.
  task automatic drain();
    while (pending_words.size() != 0 || s_tvalid || expected_tags.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic block_word_t make_word(input logic [63:0] lo, hi,
                                            input logic [4:0] cnt, input logic last);
    block_word_t w;
    w.lo = lo; w.hi = hi; w.cnt = cnt; w.last = last;
    return w;
  endfunction

  function automatic logic [63:0] key_pick();
    case ($urandom_range(3))
      0: return 64'd0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // Queue random messages: mostly full blocks, a full, partial or empty tail.
  task automatic queue_messages(input int n_words);
    int len;
    logic [4:0] cnt;
    while (n_words > 0) begin
      len = $urandom_range(5);
      for (int i = 0; i < len; i++) begin
        cnt = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'd16;
        pending_words.push_back(make_word(rand64(), rand64(), cnt, 1'b0));
      end
      cnt = ($urandom_range(2) == 0) ? 5'd16 : 5'($urandom_range(31));
      pending_words.push_back(make_word(rand64(), rand64(), cnt, 1'b1));
      n_words -= len + 1;
    end
  endtask

  initial begin
    errors = 0; send_idle_pct = 0; recv_idle_pct = 0;
    recv_hold_cycles = 0; send_pause = 0;
    key_r_lo = 0; key_r_hi = 0; key_s_lo = 0; key_s_hi = 0;
    for (int i = 0; i < 5; i++) acc[i] = '0;
    rst = 1'b1; cfg_we = 1'b0; cfg_addr = '0; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; m_tready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message with reset key, then extremes and selected byte counts.
    pending_words.push_back(make_word(0, 0, 5'd0, 1'b1));
    drain();
    load_key('1, '1, '1, '1);
    pending_words.push_back(make_word('1, '1, 5'd16, 1'b0));
    pending_words.push_back(make_word('1, '1, 5'd31, 1'b0));
    pending_words.push_back(make_word('1, '1, 5'd5, 1'b0));
    pending_words.push_back(make_word('1, '1, 5'd15, 1'b1));
    pending_words.push_back(make_word(0, 0, 5'd0, 1'b1));
    drain();
    load_key(rand64(), rand64(), rand64(), rand64());
    for (int c = 1; c <= 16; c += 1)
      if (c == 1 || c == 7 || c == 8 || c == 9 || c == 12 || c == 16 || c == 17)
        pending_words.push_back(make_word(rand64(), rand64(), 5'(c), 1'b0));
    pending_words.push_back(make_word(0, 0, 5'd17, 1'b0));
    pending_words.push_back(make_word(rand64(), rand64(), 5'd8, 1'b1));
    pending_words.push_back(make_word(rand64(), rand64(), 5'd0, 1'b0));
    pending_words.push_back(make_word(rand64(), rand64(), 5'd3, 1'b1));
    drain();

    // Random phases with changing keys and pacing.
    for (int ph = 0; ph < 6; ph++) begin
      load_key(key_pick(), key_pick(), key_pick(), key_pick());
      send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 65 : 0;
      recv_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 10 : 0;
      if (ph == 1) recv_hold_cycles = 600;
      queue_messages(160);
      if (ph == 3) begin
        // Hold the sender midway until every tag so far is out.
        while (pending_words.size() > 80) @(posedge clk);
        send_pause = 1;
        while (expected_tags.size() != 0 || s_tvalid) @(posedge clk);
        send_pause = 0;
        queue_messages(20);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/poly_pkg.sv
hdl/poly_ctrl.sv
hdl/poly_dp.sv
hdl/poly1305_mac_top.sv
verif/poly1305_mac_top_tb.sv
